### hw/rtl/jap_pkg.sv
// jap_pkg: shared types, constants and saturating helpers for the joint
// acceleration pd block; used by every module in hw/rtl
package jap_pkg;

    localparam int Q_W           = 48;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 47;
    localparam int GAIN_W        = 32;
    localparam int STEP_W        = 17;
    localparam int INV_W         = 32;
    localparam int TSQ_W         = 47;
    localparam int VLIM_W        = 47;
    localparam int COEF_W        = 47;

    // pipeline stage map
    localparam int MUL_LAT    = 4;
    localparam int S_IN       = 0;
    localparam int S_DIFF     = 1;
    localparam int S_MA       = 2;
    localparam int S_MIX      = S_MA + MUL_LAT;
    localparam int S_MB       = S_MIX + 1;
    localparam int S_WIN      = S_MB + MUL_LAT;
    localparam int S_OUT      = S_WIN + 1;
    localparam int NUM_STAGES = S_OUT + 1;

    typedef logic signed [Q_W-1:0]  q_t;
    typedef logic signed [Q_W+1:0]  qw_t;
    typedef logic [COEF_W-1:0]      coef_t;

    localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_GAIN    = 3'd0,
        CFG_VEL_GAIN    = 3'd1,
        CFG_STEP_TIME   = 3'd2,
        CFG_INV_STEP    = 3'd3,
        CFG_TWO_OVER_SQ = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_LOW  = 2'd1,
        CLAMP_HIGH = 2'd2
    } clamp_t;

    localparam logic [GAIN_W-1:0] POS_GAIN_RST  = 32'd0;
    localparam logic [GAIN_W-1:0] VEL_GAIN_RST  = 32'd0;
    localparam logic [STEP_W-1:0] STEP_TIME_RST = 17'd655;
    localparam logic [INV_W-1:0]  INV_STEP_RST  = 32'd6553600;
    localparam logic [TSQ_W-1:0]  TSQ_RST       = 47'd1310720000;

    typedef struct packed {
        logic [GAIN_W-1:0] pos_gain;
        logic [GAIN_W-1:0] vel_gain;
        logic [STEP_W-1:0] step_time;
        logic [INV_W-1:0]  inv_step;
        logic [TSQ_W-1:0]  two_over_sq;
    } cfg_t;

    // clip a two-bit-extended value to the q range
    function automatic q_t sat_q(input qw_t v);
        q_t r;
        if (v[Q_W+1:Q_W-1] == 3'b000 || v[Q_W+1:Q_W-1] == 3'b111)
            r = v[Q_W-1:0];
        else if (v[Q_W+1])
            r = Q_MIN;
        else
            r = Q_MAX;
        return r;
    endfunction

    function automatic q_t add_sat(input q_t a, input q_t b);
        qw_t s;
        s = {{2{a[Q_W-1]}}, a} + {{2{b[Q_W-1]}}, b};
        return sat_q(s);
    endfunction

    function automatic q_t sub_sat(input q_t a, input q_t b);
        qw_t s;
        s = {{2{a[Q_W-1]}}, a} - {{2{b[Q_W-1]}}, b};
        return sat_q(s);
    endfunction

    function automatic q_t neg_sat(input q_t a);
        q_t r;
        if (a == Q_MIN)
            r = Q_MAX;
        else
            r = (~a) + q_t'(1);
        return r;
    endfunction

endpackage

### hw/rtl/joint_accel_pd_with_limits.sv
// joint_accel_pd_with_limits: top level, pd acceleration command with
// position and velocity limit window; uses jap_pkg, jap_cfg, jap_flow, jap_mulq
//
// usage
//   - one request on the sample channel carries one joint: desired position,
//     velocity and acceleration, measured position and velocity, its position
//     limits and velocity limit, all signed q(47-f).f except vel_limit
//   - a request is taken at a rising edge with sample_valid high and
//     sample_stall low; one result leaves on the result channel per request,
//     in order, taken with result_valid high and result_stall low
//   - the config channel (cfg_valid/cfg_ready, always ready) writes gains,
//     step time, 1/dt and 2/dt^2; write only while no request is in flight
//   - there are 13 register stages, most of them in the two chained four-stage
//     multiplier banks; throughput is one joint per cycle while the result is
//     not stalled, and then every stage reloads each cycle
//   - reset clears all valid bits and loads the default period registers;
//     payload registers are not reset
//   - when the receiver stalls, the result holds; earlier stages keep
//     filling bubbles, so requests are still taken until every stage is full
//   - an empty window gives the braking command -kd*qd and sets limit_fault
module joint_accel_pd_with_limits #(
    parameter int FRAC_BITS = jap_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample channel
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  jap_pkg::q_t                    desired_pos,
    input  jap_pkg::q_t                    desired_vel,
    input  jap_pkg::q_t                    desired_acc,
    input  jap_pkg::q_t                    measured_pos,
    input  jap_pkg::q_t                    measured_vel,
    input  jap_pkg::q_t                    pos_low,
    input  jap_pkg::q_t                    pos_high,
    input  logic [jap_pkg::VLIM_W-1:0]     vel_limit,
    // result channel
    output logic                           result_valid,
    input  logic                           result_stall,
    output jap_pkg::q_t                    accel_cmd,
    output logic [1:0]                     clamp_kind,
    output logic                           limit_fault,
    // config channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [jap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jap_pkg::CFG_DATA_W-1:0] cfg_data
);

    // 0.001 rounded to the nearest lsb
    localparam int MARGIN_I = ((1 << FRAC_BITS) + 500) / 1000;
    localparam jap_pkg::q_t MARGIN = jap_pkg::q_t'(MARGIN_I);
    localparam int ML = jap_pkg::MUL_LAT;

    typedef struct packed {
        jap_pkg::q_t dacc;
        jap_pkg::q_t dq_lo;
        jap_pkg::q_t dq_hi;
    } sb_a_t;

    typedef struct packed {
        jap_pkg::q_t cmd;
        jap_pkg::q_t lo_v;
        jap_pkg::q_t hi_v;
        jap_pkg::q_t nbrake;
    } sb_b_t;

    jap_pkg::cfg_t                   cfg;
    logic [jap_pkg::NUM_STAGES-1:0]  en;

    // input stage
    jap_pkg::q_t                 dpos_reg, dvel_reg, dacc_reg, q_reg, qd_reg;
    jap_pkg::q_t                 plo_reg, phi_reg;
    logic [jap_pkg::VLIM_W-1:0]  vl_reg;

    // difference stage
    jap_pkg::q_t ev_reg, ep_reg, dqlo_reg, dqhi_reg, nvq_reg, vmq_reg;
    jap_pkg::q_t dacc1_reg, qd1_reg;
    jap_pkg::q_t nvq_next;
    jap_pkg::qw_t vsum, vneg;

    // multiplier bank a outputs
    jap_pkg::q_t kv, kp, drift, lo_v, hi_v, brake;
    sb_a_t       sb_a_reg [ML];

    // combine stage
    jap_pkg::q_t cmd1_reg, kp6_reg, lod_reg, hid_reg, lov6_reg, hiv6_reg, nbrake_reg;

    // multiplier bank b outputs
    jap_pkg::q_t lo_p, hi_p;
    sb_b_t       sb_b_reg [ML];
    sb_b_t       sb_b_in;

    // window stage
    jap_pkg::q_t lower_reg, upper_reg, cmd_w_reg, nbrake_w_reg;

    // output stage
    jap_pkg::q_t      accel_cmd_reg, accel_cmd_next;
    jap_pkg::clamp_t  clamp_kind_reg, clamp_kind_next;
    logic             limit_fault_reg, limit_fault_next;

    jap_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jap_flow u_flow (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .en           (en)
    );

    // ---------------- stage 0: capture request ----------------
    always_ff @(posedge clk)
    begin
        if (en[jap_pkg::S_IN])
        begin
            dpos_reg <= desired_pos;
            dvel_reg <= desired_vel;
            dacc_reg <= desired_acc;
            q_reg    <= measured_pos;
            qd_reg   <= measured_vel;
            plo_reg  <= pos_low;
            phi_reg  <= pos_high;
            vl_reg   <= vel_limit;
        end
    end

    // ---------------- stage 1: errors and limit distances ----------------
    // -(sat(vl + qd)) from one sum and one negated sum
    assign vsum = {3'b000, vl_reg} + {{2{qd_reg[jap_pkg::Q_W-1]}}, qd_reg};
    assign vneg = '0 - {3'b000, vl_reg} - {{2{qd_reg[jap_pkg::Q_W-1]}}, qd_reg};

    always_comb
    begin
        if (vsum[jap_pkg::Q_W+1] &&
            (vsum[jap_pkg::Q_W+1:jap_pkg::Q_W-1] != 3'b111 ||
             vsum[jap_pkg::Q_W-2:0] == '0))
            nvq_next = jap_pkg::Q_MAX;
        else if (!vsum[jap_pkg::Q_W+1] && vsum[jap_pkg::Q_W+1:jap_pkg::Q_W-1] != 3'b000)
            nvq_next = jap_pkg::Q_MIN + jap_pkg::q_t'(1);
        else
            nvq_next = vneg[jap_pkg::Q_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[jap_pkg::S_DIFF])
        begin
            ev_reg    <= jap_pkg::sub_sat(dvel_reg, qd_reg);
            ep_reg    <= jap_pkg::sub_sat(dpos_reg, q_reg);
            dqlo_reg  <= jap_pkg::sub_sat(plo_reg, q_reg);
            dqhi_reg  <= jap_pkg::sub_sat(phi_reg, q_reg);
            nvq_reg   <= nvq_next;
            vmq_reg   <= jap_pkg::sub_sat({1'b0, vl_reg}, qd_reg);
            dacc1_reg <= dacc_reg;
            qd1_reg   <= qd_reg;
        end
    end

    // ---------------- stages 2-5: multiplier bank a ----------------
    jap_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_kv (
        .clk (clk), .en (en[jap_pkg::S_MA +: ML]),
        .coef (jap_pkg::coef_t'(cfg.vel_gain)), .a (ev_reg), .p (kv)
    );
    jap_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_kp (
        .clk (clk), .en (en[jap_pkg::S_MA +: ML]),
        .coef (jap_pkg::coef_t'(cfg.pos_gain)), .a (ep_reg), .p (kp)
    );
    jap_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_drift (
        .clk (clk), .en (en[jap_pkg::S_MA +: ML]),
        .coef (jap_pkg::coef_t'(cfg.step_time)), .a (qd1_reg), .p (drift)
    );
    jap_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_lov (
        .clk (clk), .en (en[jap_pkg::S_MA +: ML]),
        .coef (jap_pkg::coef_t'(cfg.inv_step)), .a (nvq_reg), .p (lo_v)
    );
    jap_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_hiv (
        .clk (clk), .en (en[jap_pkg::S_MA +: ML]),
        .coef (jap_pkg::coef_t'(cfg.inv_step)), .a (vmq_reg), .p (hi_v)
    );
    jap_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_brake (
        .clk (clk), .en (en[jap_pkg::S_MA +: ML]),
        .coef (jap_pkg::coef_t'(cfg.vel_gain)), .a (qd1_reg), .p (brake)
    );

    // sideband travels alongside bank a
    always_ff @(posedge clk)
    begin
        if (en[jap_pkg::S_MA])
        begin
            sb_a_reg[0].dacc  <= dacc1_reg;
            sb_a_reg[0].dq_lo <= dqlo_reg;
            sb_a_reg[0].dq_hi <= dqhi_reg;
        end
        for (int i = 1; i < ML; i++)
            if (en[jap_pkg::S_MA + i])
                sb_a_reg[i] <= sb_a_reg[i-1];
    end

    // ---------------- stage 6: first sums, drift removal ----------------
    always_ff @(posedge clk)
    begin
        if (en[jap_pkg::S_MIX])
        begin
            cmd1_reg   <= jap_pkg::add_sat(sb_a_reg[ML-1].dacc, kv);
            kp6_reg    <= kp;
            lod_reg    <= jap_pkg::sub_sat(sb_a_reg[ML-1].dq_lo, drift);
            hid_reg    <= jap_pkg::sub_sat(sb_a_reg[ML-1].dq_hi, drift);
            lov6_reg   <= lo_v;
            hiv6_reg   <= hi_v;
            nbrake_reg <= jap_pkg::neg_sat(brake);
        end
    end

    // ---------------- stages 7-10: multiplier bank b ----------------
    jap_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_lop (
        .clk (clk), .en (en[jap_pkg::S_MB +: ML]),
        .coef (jap_pkg::coef_t'(cfg.two_over_sq)), .a (lod_reg), .p (lo_p)
    );
    jap_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_hip (
        .clk (clk), .en (en[jap_pkg::S_MB +: ML]),
        .coef (jap_pkg::coef_t'(cfg.two_over_sq)), .a (hid_reg), .p (hi_p)
    );

    // full pd command formed on entry to the sideband
    always_comb
    begin
        sb_b_in.cmd    = jap_pkg::add_sat(cmd1_reg, kp6_reg);
        sb_b_in.lo_v   = lov6_reg;
        sb_b_in.hi_v   = hiv6_reg;
        sb_b_in.nbrake = nbrake_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[jap_pkg::S_MB])
            sb_b_reg[0] <= sb_b_in;
        for (int i = 1; i < ML; i++)
            if (en[jap_pkg::S_MB + i])
                sb_b_reg[i] <= sb_b_reg[i-1];
    end

    // ---------------- stage 11: acceleration window ----------------
    always_ff @(posedge clk)
    begin
        if (en[jap_pkg::S_WIN])
        begin
            lower_reg    <= (lo_p > sb_b_reg[ML-1].lo_v) ? lo_p : sb_b_reg[ML-1].lo_v;
            upper_reg    <= (hi_p < sb_b_reg[ML-1].hi_v) ? hi_p : sb_b_reg[ML-1].hi_v;
            cmd_w_reg    <= sb_b_reg[ML-1].cmd;
            nbrake_w_reg <= sb_b_reg[ML-1].nbrake;
        end
    end

    // ---------------- stage 12: clamp decision, output register ----------------
    always_comb
    begin
        accel_cmd_next   = cmd_w_reg;
        clamp_kind_next  = jap_pkg::CLAMP_NONE;
        limit_fault_next = 1'b0;
        priority if (lower_reg >= upper_reg)
        begin
            // empty window: brake this joint
            accel_cmd_next   = nbrake_w_reg;
            limit_fault_next = 1'b1;
        end
        else if (cmd_w_reg <= lower_reg)
        begin
            accel_cmd_next  = jap_pkg::add_sat(lower_reg, MARGIN);
            clamp_kind_next = jap_pkg::CLAMP_LOW;
        end
        else if (cmd_w_reg >= upper_reg)
        begin
            accel_cmd_next  = jap_pkg::sub_sat(upper_reg, MARGIN);
            clamp_kind_next = jap_pkg::CLAMP_HIGH;
        end
        else
        begin
            accel_cmd_next = cmd_w_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[jap_pkg::S_OUT])
        begin
            accel_cmd_reg   <= accel_cmd_next;
            clamp_kind_reg  <= clamp_kind_next;
            limit_fault_reg <= limit_fault_next;
        end
    end

    assign accel_cmd   = accel_cmd_reg;
    assign clamp_kind  = clamp_kind_reg;
    assign limit_fault = limit_fault_reg;

endmodule

### hw/rtl/jap_cfg.sv
// jap_cfg: configuration register file (gains, period and its reciprocals)
// depends on jap_pkg
module jap_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [jap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jap_pkg::CFG_DATA_W-1:0] cfg_data,
    output jap_pkg::cfg_t                  cfg
);

    jap_pkg::cfg_t cfg_reg;
    jap_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (jap_pkg::cfg_idx_t'(cfg_index))
                jap_pkg::CFG_POS_GAIN:
                    cfg_next.pos_gain = cfg_data[jap_pkg::GAIN_W-1:0];
                jap_pkg::CFG_VEL_GAIN:
                    cfg_next.vel_gain = cfg_data[jap_pkg::GAIN_W-1:0];
                jap_pkg::CFG_STEP_TIME:
                    cfg_next.step_time = cfg_data[jap_pkg::STEP_W-1:0];
                jap_pkg::CFG_INV_STEP:
                    cfg_next.inv_step = cfg_data[jap_pkg::INV_W-1:0];
                jap_pkg::CFG_TWO_OVER_SQ:
                    cfg_next.two_over_sq = cfg_data[jap_pkg::TSQ_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_gain    <= jap_pkg::POS_GAIN_RST;
            cfg_reg.vel_gain    <= jap_pkg::VEL_GAIN_RST;
            cfg_reg.step_time   <= jap_pkg::STEP_TIME_RST;
            cfg_reg.inv_step    <= jap_pkg::INV_STEP_RST;
            cfg_reg.two_over_sq <= jap_pkg::TSQ_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/jap_mulq.sv
// jap_mulq: four-stage pipelined coefficient times q-value multiplier,
// truncating toward zero and saturating; depends on jap_pkg
module jap_mulq #(
    parameter int FRAC_BITS = jap_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic [jap_pkg::MUL_LAT-1:0]  en,
    input  jap_pkg::coef_t               coef,
    input  jap_pkg::q_t                  a,
    output jap_pkg::q_t                  p
);

    localparam int H      = jap_pkg::Q_W / 2;
    localparam int B1_W   = jap_pkg::COEF_W - H;
    localparam int PP_W   = 2 * H;
    localparam int PROD_W = 2 * jap_pkg::Q_W;
    localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(1) << (jap_pkg::Q_W - 1);
    localparam logic [PROD_W-1:0] LIM_POS = LIM_NEG - PROD_W'(1);

    // stage 1: sign and magnitude
    logic                     neg1_reg;
    logic [jap_pkg::Q_W-1:0]  mag_reg;
    // stage 2: partial products
    logic                     neg2_reg;
    logic [PP_W-1:0]          p00_reg, p01_reg, p10_reg, p11_reg;
    // stage 3: full product
    logic                     neg3_reg;
    logic [PROD_W-1:0]        prod_reg;
    // stage 4: result
    jap_pkg::q_t              p_reg;
    jap_pkg::q_t              p_next;

    logic [jap_pkg::Q_W-1:0]  mag_next;
    logic [H-1:0]             b0;
    logic [B1_W-1:0]          b1;
    logic [PP_W:0]            mid;
    logic [PROD_W-1:0]        prod_next;
    logic [PROD_W-1:0]        r;

    assign mag_next = a[jap_pkg::Q_W-1] ? (~a) + jap_pkg::Q_W'(1) : a;
    assign b0 = coef[H-1:0];
    assign b1 = coef[jap_pkg::COEF_W-1:H];

    assign mid       = {1'b0, p01_reg} + {1'b0, p10_reg};
    assign prod_next = {p11_reg, p00_reg} + (PROD_W'(mid) << H);

    assign r = prod_reg >> FRAC_BITS;

    always_comb
    begin
        if (neg3_reg)
        begin
            if (r > LIM_NEG)
                p_next = jap_pkg::Q_MIN;
            else
                p_next = (~r[jap_pkg::Q_W-1:0]) + jap_pkg::Q_W'(1);
        end
        else
        begin
            if (r > LIM_POS)
                p_next = jap_pkg::Q_MAX;
            else
                p_next = r[jap_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            neg1_reg <= a[jap_pkg::Q_W-1];
            mag_reg  <= mag_next;
        end
        if (en[1])
        begin
            neg2_reg <= neg1_reg;
            p00_reg  <= PP_W'(mag_reg[H-1:0] * b0);
            p01_reg  <= PP_W'(mag_reg[H-1:0] * b1);
            p10_reg  <= PP_W'(mag_reg[jap_pkg::Q_W-1:H] * b0);
            p11_reg  <= PP_W'(mag_reg[jap_pkg::Q_W-1:H] * b1);
        end
        if (en[2])
        begin
            neg3_reg <= neg2_reg;
            prod_reg <= prod_next;
        end
        if (en[3])
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### hw/rtl/jap_flow.sv
// jap_flow: per-stage valid bits and load enables for the datapath
// pipeline, collapsing bubbles under a stalled result; depends on jap_pkg
module jap_flow (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [jap_pkg::NUM_STAGES-1:0]  en
);

    localparam int N = jap_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] ready;
    logic [N-1:0] upper_mask;

    // a stage may load when it or any stage after it holds a bubble,
    // or when the output is being taken
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            upper_mask = {N{1'b1}} << k;
            ready[k]   = !(&(valid_reg | ~upper_mask)) || !result_stall;
        end
    end

    assign en           = ready;
    assign sample_stall = !ready[0];
    assign result_valid = valid_reg[N-1];

    always_comb
    begin
        valid_next[0] = sample_valid;
        for (int k = 1; k < N; k++)
            valid_next[k] = valid_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
                if (ready[k])
                    valid_reg[k] <= valid_next[k];
        end
    end

endmodule

### hw/rtl/jap_checker.sv
// jap_checker: port-level assertions for joint_accel_pd_with_limits, bound
// to the top level; depends on jap_pkg
module jap_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_valid,
    input  logic        result_stall,
    input  jap_pkg::q_t accel_cmd,
    input  logic [1:0]  clamp_kind,
    input  logic        limit_fault
);

    // no result while reset is held
    a_no_result_in_reset: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // a stalled result stays put
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(accel_cmd) && $stable(clamp_kind) &&
            $stable(limit_fault))
        else $error("stalled result changed");

    // braking result never also reports a clamp
    a_fault_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && limit_fault |-> clamp_kind == jap_pkg::CLAMP_NONE)
        else $error("fault with clamp kind set");

    // clamp kind only takes its three defined codes
    a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (clamp_kind == jap_pkg::CLAMP_NONE ||
                          clamp_kind == jap_pkg::CLAMP_LOW ||
                          clamp_kind == jap_pkg::CLAMP_HIGH))
        else $error("undefined clamp kind");

endmodule

bind joint_accel_pd_with_limits jap_checker u_jap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accel_cmd    (accel_cmd),
    .clamp_kind   (clamp_kind),
    .limit_fault  (limit_fault)
);
